/* src/bfac_pkg.sv */
// ----------------------------------------------------------------------------
// bfac_pkg
// Shared codes, register map and reset values for the backlight controller.
// ----------------------------------------------------------------------------
`default_nettype none

package bfac_pkg;

    // Command codes carried on the input channel's tuser
    typedef enum logic [1:0] {
        CMD_SET_LEVEL = 2'd0,
        CMD_FADE_TICK = 2'd1,
        CMD_MON_TICK  = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_t;

    // Register indexes (byte address = 4 * index)
    localparam int unsigned ADDR_W    = 5;
    localparam logic [2:0] REG_AUTO_SLEEP = 3'd0;
    localparam logic [2:0] REG_TIMEOUT    = 3'd1;
    localparam logic [2:0] REG_DIM_LEVEL  = 3'd2;
    localparam logic [2:0] REG_FADE_ON    = 3'd3;
    localparam logic [2:0] REG_FADE_DELTA = 3'd4;
    localparam logic [2:0] REG_FULL_SCALE = 3'd5;

    // Register reset values
    localparam logic        RST_AUTO_SLEEP = 1'b1;
    localparam logic [31:0] RST_TIMEOUT    = 32'd30000;
    localparam logic [7:0]  RST_DIM_LEVEL  = 8'd32;
    localparam logic        RST_FADE_ON    = 1'b1;
    localparam logic [7:0]  RST_FADE_DELTA = 8'd5;
    localparam logic [15:0] RST_FULL_SCALE = 16'd255;

    // Brightness state comes out of reset at full on
    localparam logic [7:0]  LEVEL_MAX      = 8'd255;

endpackage : bfac_pkg

`default_nettype wire

/* src/backlight_fade_autodim_controller.sv */
// ----------------------------------------------------------------------------
// backlight_fade_autodim_controller
// Backlight brightness control with fade ramp, auto-dim on inactivity and
// inverted PWM duty output.
// ----------------------------------------------------------------------------
// The result is registered: it is valid on the m_ side in the cycle after input accept.
// Throughput: 1 item per cycle; the output register is refilled in the same
//   cycle it is drained, so the input stalls only while a held result is not taken.
// Reset: aresetn synchronous, active low; registers return to their defaults,
//   brightness/target/saved level to full on, awake, last inactivity 0.
`default_nettype none

module backlight_fade_autodim_controller
    import bfac_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    // Input items
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [39:0]         s_tdata,   // [7:0] level, [39:8] inactive_ms
    input  wire logic [1:0]          s_tuser,   // [1:0] cmd

    // Result items
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [39:0]              m_tdata,   // [15:0] duty, [23:16] brightness,
                                                // [31:24] target, [32] asleep, zero pad

    // Configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        auto_sleep_reg;
    logic [31:0] timeout_reg;
    logic [7:0]  dim_level_reg;
    logic        fade_on_reg;
    logic [7:0]  fade_delta_reg;
    logic [15:0] full_scale_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_sleep_reg <= RST_AUTO_SLEEP;
            timeout_reg    <= RST_TIMEOUT;
            dim_level_reg  <= RST_DIM_LEVEL;
            fade_on_reg    <= RST_FADE_ON;
            fade_delta_reg <= RST_FADE_DELTA;
            full_scale_reg <= RST_FULL_SCALE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_AUTO_SLEEP: auto_sleep_reg <= pwdata[0];
                REG_TIMEOUT:    timeout_reg    <= pwdata;
                REG_DIM_LEVEL:  dim_level_reg  <= pwdata[7:0];
                REG_FADE_ON:    fade_on_reg    <= pwdata[0];
                REG_FADE_DELTA: fade_delta_reg <= pwdata[7:0];
                REG_FULL_SCALE: full_scale_reg <= pwdata[15:0];
                default: ;  // unmapped: write dropped
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (cfg_idx)
            REG_AUTO_SLEEP: prdata = {31'd0, auto_sleep_reg};
            REG_TIMEOUT:    prdata = timeout_reg;
            REG_DIM_LEVEL:  prdata = {24'd0, dim_level_reg};
            REG_FADE_ON:    prdata = {31'd0, fade_on_reg};
            REG_FADE_DELTA: prdata = {24'd0, fade_delta_reg};
            REG_FULL_SCALE: prdata = {16'd0, full_scale_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    logic [7:0]  cur_reg,   cur_next;
    logic [7:0]  tgt_reg,   tgt_next;
    logic [7:0]  saved_reg, saved_next;
    logic        sleep_reg, sleep_next;
    logic [31:0] last_reg,  last_next;

    // Output register
    logic        m_valid_reg;
    logic [39:0] m_data_reg, m_data_next;

    logic        s_acc;
    cmd_t        cmd;
    logic [7:0]  in_level;
    logic [31:0] in_inactive;

    assign s_tready    = ~m_valid_reg | m_tready;
    assign s_acc       = s_tvalid & s_tready;
    assign cmd         = cmd_t'(s_tuser);
    assign in_level    = s_tdata[7:0];
    assign in_inactive = s_tdata[39:8];

    // Fade step toward target, clamped at target
    logic [8:0] up_sum;
    logic [7:0] down_gap;
    logic [7:0] fade_val;

    always_comb begin
        up_sum   = {1'b0, cur_reg} + {1'b0, fade_delta_reg};
        down_gap = cur_reg - tgt_reg;
        if (cur_reg == tgt_reg) begin
            fade_val = cur_reg;
        end else if (tgt_reg > cur_reg) begin
            fade_val = (up_sum > {1'b0, tgt_reg}) ? tgt_reg : up_sum[7:0];
        end else begin
            fade_val = (down_gap < fade_delta_reg) ? tgt_reg : cur_reg - fade_delta_reg;
        end
    end

    // Next state per command
    always_comb begin
        cur_next   = cur_reg;
        tgt_next   = tgt_reg;
        saved_next = saved_reg;
        sleep_next = sleep_reg;
        last_next  = last_reg;
        case (cmd)
            CMD_SET_LEVEL: begin
                tgt_next = in_level;
                if (!fade_on_reg) cur_next = in_level;
            end
            CMD_FADE_TICK: begin
                cur_next = fade_val;
            end
            CMD_MON_TICK: begin
                if (!auto_sleep_reg) begin
                    last_next = 32'd0;
                end else begin
                    if (in_inactive >= timeout_reg && !sleep_reg) begin
                        // going to sleep: remember brightness, head for dim level
                        sleep_next = 1'b1;
                        saved_next = cur_reg;
                        tgt_next   = dim_level_reg;
                        if (!fade_on_reg) cur_next = dim_level_reg;
                    end else if (sleep_reg && in_inactive < last_reg) begin
                        // activity seen: restore saved brightness
                        sleep_next = 1'b0;
                        tgt_next   = saved_reg;
                        if (!fade_on_reg) cur_next = saved_reg;
                    end
                    last_next = in_inactive;
                end
            end
            default: ;  // unused code: state unchanged
        endcase
    end

    // Result: duty saturates at 0 when full scale is below brightness
    logic [15:0] duty;
    always_comb begin
        duty = (full_scale_reg >= {8'd0, cur_next}) ? full_scale_reg - {8'd0, cur_next}
                                                    : 16'd0;
        m_data_next = {7'd0, sleep_next, tgt_next, cur_next, duty};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg     <= LEVEL_MAX;
            tgt_reg     <= LEVEL_MAX;
            saved_reg   <= LEVEL_MAX;
            sleep_reg   <= 1'b0;
            last_reg    <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                cur_reg   <= cur_next;
                tgt_reg   <= tgt_next;
                saved_reg <= saved_next;
                sleep_reg <= sleep_next;
                last_reg  <= last_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule : backlight_fade_autodim_controller

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the backlight controller: a directed pass over the
// fade, auto-dim and duty corner cases, then randomized command streams under
// several register settings. Every result is checked against a local model.
// ----------------------------------------------------------------------------

module tb
    import bfac_pkg::*;
;

    // Register slots past the end of the map; writes there must be ignored
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1650;

    // Receiver back-pressure modes
    typedef enum logic [1:0] {
        RX_OPEN,     // always ready
        RX_RANDOM,   // ready about 70% of cycles
        RX_SPARSE    // ready one cycle in four
    } rx_mode_e;

    // One result item, as predicted
    typedef struct packed {
        logic [15:0] duty;
        logic [7:0]  brightness;
        logic [7:0]  target;
        logic        asleep;
    } backlight_report_t;

    // ------------------------------------------------------------------------
    // Tracks registers and brightness state, predicts each result and checks
    // results in order against the predictions.
    // ------------------------------------------------------------------------
    class backlight_tracker;
        logic        auto_sleep;
        logic [31:0] sleep_tmo;
        logic [7:0]  dim_level;
        logic        fade_en;
        logic [7:0]  fade_delta;
        logic [15:0] full_scale;

        logic [7:0]  cur_level;
        logic [7:0]  tgt_level;
        logic [7:0]  saved_level;
        logic        sleeping;
        logic [31:0] last_inactive;

        backlight_report_t reports[$];
        int          errors;

        function new();
            auto_sleep    = RST_AUTO_SLEEP;
            sleep_tmo     = RST_TIMEOUT;
            dim_level     = RST_DIM_LEVEL;
            fade_en       = RST_FADE_ON;
            fade_delta    = RST_FADE_DELTA;
            full_scale    = RST_FULL_SCALE;
            cur_level     = LEVEL_MAX;
            tgt_level     = LEVEL_MAX;
            saved_level   = LEVEL_MAX;
            sleeping      = 1'b0;
            last_inactive = '0;
            errors        = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_AUTO_SLEEP: auto_sleep = value[0];
                REG_TIMEOUT:    sleep_tmo  = value;
                REG_DIM_LEVEL:  dim_level  = value[7:0];
                REG_FADE_ON:    fade_en    = value[0];
                REG_FADE_DELTA: fade_delta = value[7:0];
                REG_FULL_SCALE: full_scale = value[15:0];
                default: ;
            endcase
        endfunction

        // new target; jumps straight there when fading is off
        function void request(logic [7:0] lvl);
            tgt_level = lvl;
            if (!fade_en)
                cur_level = lvl;
        endfunction

        function void note_item(cmd_t cmd, logic [7:0] lvl, logic [31:0] inactive_ms);
            logic [8:0]        sum;
            backlight_report_t r;
            case (cmd)
                CMD_SET_LEVEL: request(lvl);
                CMD_FADE_TICK: begin
                    // one step toward target, clamped; ignores fade_en
                    if (tgt_level > cur_level) begin
                        sum = cur_level + fade_delta;
                        cur_level = (sum > tgt_level) ? tgt_level : sum[7:0];
                    end else if (tgt_level < cur_level) begin
                        cur_level = (cur_level - tgt_level < fade_delta) ?
                                    tgt_level : cur_level - fade_delta;
                    end
                end
                CMD_MON_TICK: begin
                    if (!auto_sleep) begin
                        last_inactive = '0;
                    end else begin
                        if (inactive_ms >= sleep_tmo && !sleeping) begin
                            sleeping    = 1'b1;
                            saved_level = cur_level;
                            request(dim_level);
                        end else if (sleeping && inactive_ms < last_inactive) begin
                            sleeping = 1'b0;
                            request(saved_level);
                        end
                        last_inactive = inactive_ms;
                    end
                end
                default: ;
            endcase
            r.duty       = (full_scale >= cur_level) ? full_scale - cur_level : '0;
            r.brightness = cur_level;
            r.target     = tgt_level;
            r.asleep     = sleeping;
            reports.push_back(r);
        endfunction

        function void mismatch(string field, longint unsigned want, longint unsigned got);
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        endfunction

        function void check_result(logic [39:0] data);
            backlight_report_t want;
            if (reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h", $time, data);
                return;
            end
            want = reports.pop_front();
            if (data[15:0] !== want.duty)        mismatch("duty", want.duty, data[15:0]);
            if (data[23:16] !== want.brightness) mismatch("brightness", want.brightness,
                                                          data[23:16]);
            if (data[31:24] !== want.target)     mismatch("target", want.target, data[31:24]);
            if (data[32] !== want.asleep)        mismatch("asleep", want.asleep, data[32]);
            if (data[39:33] !== '0)              mismatch("pad", 0, data[39:33]);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block I/O
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;

    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [39:0] s_tdata  = '0;     // [7:0] level, [39:8] inactive_ms
    logic [1:0]  s_tuser  = '0;     // [1:0] cmd

    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [39:0] m_tdata;           // [15:0] duty, [23:16] brightness, [31:24] target,
                                    // [32] asleep, [39:33] zero

    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    wire  [31:0] prdata;
    wire         pready;

    always #5 aclk = ~aclk;

    backlight_fade_autodim_controller DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    backlight_tracker trk = new();

    // ------------------------------------------------------------------------
    // Observation: all handshakes are sampled at the rising edge, before any
    // nonblocking update of that edge lands. Results are checked before the
    // item of the same edge is noted, since a result always belongs to an
    // earlier item.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                trk.check_result(m_tdata);
            if (s_tvalid && s_tready)
                trk.note_item(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[39:8]);
            if (psel && penable && pwrite && pready)
                trk.write_reg(paddr[4:2], pwdata);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: back-pressure mode is redrawn each time its random run length runs
    // out, so open stretches alternate with heavy stalling.
    // ------------------------------------------------------------------------
    rx_mode_e rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       rx_phase  = 0;

    always @(posedge aclk) begin
        if (mode_left == 0) begin
            rx_mode   <= rx_mode_e'($urandom_range(0, 2));
            mode_left <= $urandom_range(32, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(0, 9) < 7);
            default:   m_tready <= (rx_phase % 4 == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Sender and config tasks. All are entered right after a rising edge.
    // ------------------------------------------------------------------------
    int          burst_left = 0;
    logic [31:0] ina_walk   = '0;

    // One item, with a random gap whenever the current burst runs out
    task automatic push_item(input cmd_t c, input logic [7:0] lvl, input logic [31:0] ina);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {ina, lvl};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and wait until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (trk.reports.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);   // a little margin after the last result
    endtask

    // Setup then access phase; then an idle wait so psel drops cleanly
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic auto_on, input logic [31:0] tmo,
                                input logic [7:0] dim, input logic fade,
                                input logic [7:0] delta, input logic [15:0] fs);
        apb_write(REG_AUTO_SLEEP, {31'd0, auto_on});
        apb_write(REG_TIMEOUT, tmo);
        apb_write(REG_DIM_LEVEL, {24'd0, dim});
        apb_write(REG_FADE_ON, {31'd0, fade});
        apb_write(REG_FADE_DELTA, {24'd0, delta});
        apb_write(REG_FULL_SCALE, {16'd0, fs});
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Monitor-tick inactivity: mostly a rising walk (user idle), sometimes a
    // drop back (user touched the screen), plus raw noise and extremes.
    function automatic logic [31:0] pick_inactive(logic [31:0] tmo);
        case ($urandom_range(0, 19))
            0, 1:    ina_walk = $urandom_range(0, 50);
            2:       return $urandom;
            3:       return 32'hFFFF_FFFF;
            4:       return '0;
            default: ina_walk = ina_walk + ((tmo > 32'd4000) ? $urandom : $urandom_range(0, 800));
        endcase
        return ina_walk;
    endfunction

    task automatic push_random();
        int          roll;
        logic [7:0]  lvl;
        logic [31:0] ina;
        roll = $urandom_range(0, 99);
        lvl  = pick_level();
        ina  = $urandom;
        if (roll < 30)
            push_item(CMD_SET_LEVEL, lvl, ina);
        else if (roll < 63)
            push_item(CMD_FADE_TICK, lvl, ina);
        else if (roll < 95)
            push_item(CMD_MON_TICK, lvl, pick_inactive(trk.sleep_tmo));
        else
            push_item(CMD_NONE, lvl, ina);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int          sent;
        int          n;
        logic        auto_on;
        logic        fade;
        logic [31:0] tmo;
        logic [7:0]  dim;
        logic [7:0]  delta;
        logic [15:0] fs;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- Directed, reset settings: idle code, fade ramp, sleep and wake
        push_item(CMD_NONE, 8'hFF, 32'hFFFF_FFFF);   // unused code, nothing moves
        push_item(CMD_SET_LEVEL, 8'd0, 32'hFFFF_FFFF);
        push_item(CMD_FADE_TICK, 8'hFF, '0);
        push_item(CMD_FADE_TICK, 8'h00, '0);
        push_item(CMD_MON_TICK, 8'hAA, 32'd0);
        push_item(CMD_MON_TICK, 8'h55, 32'd30000);    // exactly at timeout: sleep
        push_item(CMD_MON_TICK, 8'h00, 32'hFFFF_FFFF); // asleep, no drop: stays
        push_item(CMD_FADE_TICK, 8'h00, '0);
        push_item(CMD_MON_TICK, 8'h00, 32'd1);        // drop: wake, restore
        push_item(CMD_SET_LEVEL, 8'd255, '0);
        drain();

        // fade switched off mid-ramp: ticks still step, a set jumps
        apb_write(REG_FADE_ON, 32'd0);
        push_item(CMD_FADE_TICK, 8'h00, '0);
        push_item(CMD_FADE_TICK, 8'h00, '0);
        push_item(CMD_SET_LEVEL, 8'd7, '0);
        drain();

        // zero step: fade ticks hold
        program_regs(1'b1, RST_TIMEOUT, RST_DIM_LEVEL, 1'b1, 8'd0, RST_FULL_SCALE);
        push_item(CMD_SET_LEVEL, 8'd200, '0);
        push_item(CMD_FADE_TICK, 8'h00, '0);
        drain();

        // auto-sleep off: a tick only clears the stored inactivity
        apb_write(REG_AUTO_SLEEP, 32'd0);
        push_item(CMD_MON_TICK, 8'h00, 32'hFFFF_FFFF);
        drain();

        // zero timeout, zero full scale (duty saturates), max step and dim
        program_regs(1'b1, 32'd0, 8'd255, 1'b1, 8'd255, 16'd0);
        push_item(CMD_MON_TICK, 8'h00, 32'd0);
        push_item(CMD_FADE_TICK, 8'h00, '0);
        push_item(CMD_SET_LEVEL, 8'd128, '0);
        drain();

        // max timeout and full scale; write to a slot past the map
        program_regs(1'b1, 32'hFFFF_FFFF, 8'd0, 1'b0, 8'd1, 16'hFFFF);
        apb_write(REG_SPARE_LO, $urandom);
        apb_write(REG_SPARE_HI, $urandom);
        push_item(CMD_MON_TICK, 8'h00, 32'hFFFF_FFFE);
        push_item(CMD_MON_TICK, 8'h00, 32'hFFFF_FFFF);
        push_item(CMD_NONE, 8'h00, '0);
        drain();

        // --- Random phases, each under a fresh register setting
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            auto_on = ($urandom_range(0, 4) != 0);
            fade    = $urandom_range(0, 1);
            case ($urandom_range(0, 9))
                0:       tmo = 32'd0;
                1:       tmo = 32'd1;
                2:       tmo = 32'hFFFF_FFFF;
                3:       tmo = $urandom;
                default: tmo = $urandom_range(1, 4000);
            endcase
            dim = pick_level();
            case ($urandom_range(0, 9))
                0:       delta = 8'd0;
                1:       delta = 8'd1;
                2:       delta = 8'd255;
                default: delta = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 7))
                0:       fs = 16'd0;
                1:       fs = 16'hFFFF;
                2:       fs = 16'($urandom);
                3:       fs = $urandom_range(0, 254);
                default: fs = RST_FULL_SCALE;
            endcase
            program_regs(auto_on, tmo, dim, fade, delta, fs);

            n = $urandom_range(60, 220);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            repeat (n) begin
                push_random();
                sent++;
            end
            drain();
        end

        if (trk.errors == 0 && trk.reports.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

/* backlight_fade_autodim_controller.f */
src/bfac_pkg.sv
src/backlight_fade_autodim_controller.sv
tb/tb.sv
